/* sv/mtrc_pkg.sv */
package mtrc_pkg;

  localparam int unsigned AddrW = 4;

  localparam logic [2:0] REQ_SAMPLE       = 3'd0;
  localparam logic [2:0] REQ_HEALTH       = 3'd1;
  localparam logic [2:0] REQ_MANUAL_START = 3'd2;
  localparam logic [2:0] REQ_MANUAL_STOP  = 3'd3;
  localparam logic [2:0] REQ_FORCED_STOP  = 3'd4;

  localparam logic [2:0] STOP_NONE       = 3'd0;
  localparam logic [2:0] STOP_MANUAL     = 3'd1;
  localparam logic [2:0] STOP_FORCED     = 3'd2;
  localparam logic [2:0] STOP_LOW_STORE  = 3'd3;
  localparam logic [2:0] STOP_WRITE_ERR  = 3'd4;
  localparam logic [2:0] STOP_STATIONARY = 3'd5;

  localparam logic [2:0] NOTE_NONE      = 3'd0;
  localparam logic [2:0] NOTE_STALE     = 3'd1;
  localparam logic [2:0] NOTE_RECOVERED = 3'd2;
  localparam logic [2:0] NOTE_CANDIDATE = 3'd3;
  localparam logic [2:0] NOTE_RESUMED   = 3'd4;

  localparam logic [1:0] REG_START_SPEED = 2'd0;
  localparam logic [1:0] REG_STOP_SPEED  = 2'd1;
  localparam logic [1:0] REG_STOP_DELAY  = 2'd2;
  localparam logic [1:0] REG_STALE_LIMIT = 2'd3;

  localparam logic [13:0] START_SPEED_RST = 14'd1000;
  localparam logic [13:0] STOP_SPEED_RST  = 14'd300;
  localparam logic [19:0] STOP_DELAY_RST  = 20'd30000;
  localparam logic [15:0] STALE_LIMIT_RST = 16'd1000;

  localparam logic [31:0] AGE_UNKNOWN = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        recording;
    logic        manual_mode;
    logic        session_started;
    logic        sample_written;
    logic [2:0]  stop_code;
    logic        finalize_file;
    logic        accepted;
    logic [2:0]  notice_code;
    logic [31:0] sample_count;
    logic [15:0] dropout_count;
    logic [31:0] invalid_count;
    logic [31:0] max_packet_age;
  } result_t;

endpackage

/* sv/motion_triggered_record_control.sv */
// A result is registered in the result register, or first in the skid register while the result register is stalled.
// Throughput: one event per clock while the input is not stalled; all decisions settle in one combinational pass
// from the input ports into the result register or the skid register.
// A one-entry skid register behind the result register keeps the input taking
// events while a finished result is stalled; the input stalls only when both are full.
// Reset (rst_ni low, asynchronous) clears session state and counters and loads defaults.
module motion_triggered_record_control (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mtrc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 req_type_i,
  input  logic [31:0]                now_ms_i,
  input  logic                       fix_valid_i,
  input  logic [15:0]                speed_i,
  input  logic                       connected_i,
  input  logic [31:0]                packet_age_ms_i,
  input  logic                       storage_ok_i,
  input  logic                       write_ok_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       recording_o,
  output logic                       manual_mode_o,
  output logic                       session_started_o,
  output logic                       sample_written_o,
  output logic [2:0]                 stop_code_o,
  output logic                       finalize_file_o,
  output logic                       accepted_o,
  output logic [2:0]                 notice_code_o,
  output logic [31:0]                sample_count_o,
  output logic [15:0]                dropout_count_o,
  output logic [31:0]                invalid_count_o,
  output logic [31:0]                max_packet_age_o
);

  // Configuration registers
  logic [13:0] start_speed_q;
  logic [13:0] stop_speed_q;
  logic [19:0] stop_delay_q;
  logic [15:0] stale_limit_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_speed_q <= mtrc_pkg::START_SPEED_RST;
      stop_speed_q  <= mtrc_pkg::STOP_SPEED_RST;
      stop_delay_q  <= mtrc_pkg::STOP_DELAY_RST;
      stale_limit_q <= mtrc_pkg::STALE_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        mtrc_pkg::REG_START_SPEED: start_speed_q <= pwdata[13:0];
        mtrc_pkg::REG_STOP_SPEED:  stop_speed_q  <= pwdata[13:0];
        mtrc_pkg::REG_STOP_DELAY:  stop_delay_q  <= pwdata[19:0];
        mtrc_pkg::REG_STALE_LIMIT: stale_limit_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mtrc_pkg::REG_START_SPEED: prdata = {18'd0, start_speed_q};
      mtrc_pkg::REG_STOP_SPEED:  prdata = {18'd0, stop_speed_q};
      mtrc_pkg::REG_STOP_DELAY:  prdata = {12'd0, stop_delay_q};
      mtrc_pkg::REG_STALE_LIMIT: prdata = {16'd0, stale_limit_q};
      default:                   prdata = '0;
    endcase
  end

  // Session state
  logic        rec_q, rec_d;
  logic        man_q, man_d;
  logic        inhibit_q, inhibit_d;
  logic        stale_q, stale_d;
  logic        below_q, below_d;
  logic [31:0] since_q, since_d;
  logic        cand_q, cand_d;
  logic [31:0] samples_q, samples_d;
  logic [15:0] drops_q, drops_d;
  logic [31:0] invalid_q, invalid_d;
  logic [31:0] max_age_q, max_age_d;

  logic        started, written, finalize, acc;
  logic [2:0]  stop_code, notice;
  logic        proceed, is_stale;
  logic [31:0] elapsed;

  logic        in_accept;
  mtrc_pkg::result_t res;

  always_comb begin
    rec_d     = rec_q;
    man_d     = man_q;
    inhibit_d = inhibit_q;
    stale_d   = stale_q;
    below_d   = below_q;
    since_d   = since_q;
    cand_d    = cand_q;
    samples_d = samples_q;
    drops_d   = drops_q;
    invalid_d = invalid_q;
    max_age_d = max_age_q;
    started   = 1'b0;
    written   = 1'b0;
    finalize  = 1'b0;
    acc       = 1'b1;
    stop_code = mtrc_pkg::STOP_NONE;
    notice    = mtrc_pkg::NOTE_NONE;
    proceed   = 1'b1;
    is_stale  = 1'b0;
    elapsed   = '0;

    unique case (req_type_i)
      mtrc_pkg::REQ_SAMPLE: begin
        if (!fix_valid_i) begin
          if (rec_q) begin
            if (invalid_q != '1) invalid_d = invalid_q + 32'd1;
            below_d = 1'b0;
            since_d = '0;
            cand_d  = 1'b0;
          end
        end else if (rec_q && man_q) begin
          if (!storage_ok_i) begin
            stop_code = mtrc_pkg::STOP_LOW_STORE;
            finalize  = 1'b1;
            rec_d = 1'b0; man_d = 1'b0; below_d = 1'b0; since_d = '0; cand_d = 1'b0;
          end else if (!write_ok_i) begin
            stop_code = mtrc_pkg::STOP_WRITE_ERR;
            rec_d = 1'b0; man_d = 1'b0; below_d = 1'b0; since_d = '0; cand_d = 1'b0;
          end else begin
            if (samples_q != '1) samples_d = samples_q + 32'd1;
            written = 1'b1;
          end
        end else begin
          // After a manual stop, auto start waits until the speed drops below the threshold.
          if (inhibit_q) begin
            if (speed_i < {2'd0, start_speed_q}) inhibit_d = 1'b0;
            else proceed = 1'b0;
          end
          if (proceed) begin
            if (!rec_q && speed_i >= {2'd0, start_speed_q} && storage_ok_i) begin
              rec_d = 1'b1; man_d = 1'b0; inhibit_d = 1'b0; stale_d = 1'b0;
              below_d = 1'b0; since_d = '0; cand_d = 1'b0;
              samples_d = '0; drops_d = '0; invalid_d = '0; max_age_d = '0;
              started = 1'b1;
            end
            if (rec_d) begin
              if (!storage_ok_i) begin
                stop_code = mtrc_pkg::STOP_LOW_STORE;
                finalize  = 1'b1;
                rec_d = 1'b0; man_d = 1'b0; below_d = 1'b0; since_d = '0; cand_d = 1'b0;
              end else if (!write_ok_i) begin
                stop_code = mtrc_pkg::STOP_WRITE_ERR;
                rec_d = 1'b0; man_d = 1'b0; below_d = 1'b0; since_d = '0; cand_d = 1'b0;
              end else begin
                if (samples_d != '1) samples_d = samples_d + 32'd1;
                written = 1'b1;
                if (stale_d) begin
                  below_d = 1'b0; since_d = '0; cand_d = 1'b0;
                end else if (speed_i <= {2'd0, stop_speed_q}) begin
                  if (!below_d) begin
                    below_d = 1'b1;
                    since_d = now_ms_i;
                    if (!cand_d) begin
                      notice = mtrc_pkg::NOTE_CANDIDATE;
                      cand_d = 1'b1;
                    end
                  end
                  elapsed = now_ms_i - since_d;
                  if (elapsed >= {12'd0, stop_delay_q}) begin
                    stop_code = mtrc_pkg::STOP_STATIONARY;
                    finalize  = 1'b1;
                    rec_d = 1'b0; man_d = 1'b0; below_d = 1'b0; since_d = '0; cand_d = 1'b0;
                  end
                end else begin
                  if (below_d) notice = mtrc_pkg::NOTE_RESUMED;
                  below_d = 1'b0; since_d = '0; cand_d = 1'b0;
                end
              end
            end
          end
        end
      end
      mtrc_pkg::REQ_HEALTH: begin
        if (rec_q) begin
          if (packet_age_ms_i != mtrc_pkg::AGE_UNKNOWN && packet_age_ms_i > max_age_q) begin
            max_age_d = packet_age_ms_i;
          end
          is_stale = !connected_i || packet_age_ms_i == mtrc_pkg::AGE_UNKNOWN
                     || packet_age_ms_i > {16'd0, stale_limit_q};
          if (is_stale && !stale_q) begin
            stale_d = 1'b1;
            if (drops_q != '1) drops_d = drops_q + 16'd1;
            below_d = 1'b0; since_d = '0; cand_d = 1'b0;
            notice = mtrc_pkg::NOTE_STALE;
          end else if (!is_stale && stale_q) begin
            stale_d = 1'b0;
            notice  = mtrc_pkg::NOTE_RECOVERED;
          end
          if (!fix_valid_i) begin
            below_d = 1'b0; since_d = '0; cand_d = 1'b0;
          end
        end
      end
      mtrc_pkg::REQ_MANUAL_START: begin
        if (!fix_valid_i) begin
          acc = 1'b0;
        end else if (rec_q) begin
          man_d     = 1'b1;
          inhibit_d = 1'b0;
        end else if (storage_ok_i) begin
          rec_d = 1'b1; man_d = 1'b1; inhibit_d = 1'b0; stale_d = 1'b0;
          below_d = 1'b0; since_d = '0; cand_d = 1'b0;
          samples_d = '0; drops_d = '0; invalid_d = '0; max_age_d = '0;
          started = 1'b1;
        end else begin
          acc = 1'b0;
        end
      end
      mtrc_pkg::REQ_MANUAL_STOP: begin
        if (!rec_q) begin
          acc = 1'b0;
        end else begin
          stop_code = mtrc_pkg::STOP_MANUAL;
          finalize  = 1'b1;
          rec_d = 1'b0; man_d = 1'b0; below_d = 1'b0; since_d = '0; cand_d = 1'b0;
          inhibit_d = 1'b1;
        end
      end
      mtrc_pkg::REQ_FORCED_STOP: begin
        if (rec_q) begin
          stop_code = mtrc_pkg::STOP_FORCED;
          finalize  = 1'b1;
          rec_d = 1'b0; man_d = 1'b0; below_d = 1'b0; since_d = '0; cand_d = 1'b0;
        end
      end
      default: ;
    endcase

    res.recording       = rec_d;
    res.manual_mode     = rec_d & man_d;
    res.session_started = started;
    res.sample_written  = written;
    res.stop_code       = stop_code;
    res.finalize_file   = finalize;
    res.accepted        = acc;
    res.notice_code     = notice;
    res.sample_count    = samples_d;
    res.dropout_count   = drops_d;
    res.invalid_count   = invalid_d;
    res.max_packet_age  = max_age_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q     <= 1'b0;
      man_q     <= 1'b0;
      inhibit_q <= 1'b0;
      stale_q   <= 1'b0;
      below_q   <= 1'b0;
      since_q   <= '0;
      cand_q    <= 1'b0;
      samples_q <= '0;
      drops_q   <= '0;
      invalid_q <= '0;
      max_age_q <= '0;
    end else if (in_accept) begin
      rec_q     <= rec_d;
      man_q     <= man_d;
      inhibit_q <= inhibit_d;
      stale_q   <= stale_d;
      below_q   <= below_d;
      since_q   <= since_d;
      cand_q    <= cand_d;
      samples_q <= samples_d;
      drops_q   <= drops_d;
      invalid_q <= invalid_d;
      max_age_q <= max_age_d;
    end
  end

  // Result register with a one-entry skid register behind it
  logic              out_vld_q, out_vld_d;
  logic              skid_vld_q, skid_vld_d;
  mtrc_pkg::result_t out_q, out_d;
  mtrc_pkg::result_t skid_q, skid_d;
  logic              out_free;

  assign in_stall_o = skid_vld_q;
  assign in_accept  = in_valid_i & ~skid_vld_q;
  assign out_free   = ~out_vld_q | ~out_stall_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = in_accept;
      end
    end else if (in_accept) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = out_vld_q;
  assign recording_o       = out_q.recording;
  assign manual_mode_o     = out_q.manual_mode;
  assign session_started_o = out_q.session_started;
  assign sample_written_o  = out_q.sample_written;
  assign stop_code_o       = out_q.stop_code;
  assign finalize_file_o   = out_q.finalize_file;
  assign accepted_o        = out_q.accepted;
  assign notice_code_o     = out_q.notice_code;
  assign sample_count_o    = out_q.sample_count;
  assign dropout_count_o   = out_q.dropout_count;
  assign invalid_count_o   = out_q.invalid_count;
  assign max_packet_age_o  = out_q.max_packet_age;

`ifndef SYNTHESIS
  // The skid register only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the result register is empty");

  a_manual_needs_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    man_q |-> rec_q)
    else $error("manual control flag set without an active session");

  a_stop_ends_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.stop_code != mtrc_pkg::STOP_NONE) |-> !out_q.recording)
    else $error("result reports a stop while still recording");

  // A new session may end on its very first sample, so only the count is checked here.
  a_start_fresh_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.session_started) |-> (out_q.sample_count <= 32'd1))
    else $error("session start reported with inconsistent state");

  a_idle_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rec_q |-> (!below_q && !cand_q))
    else $error("stationary timer running while idle");
`endif

endmodule
